// ===== rtl/binary_min_heap_queue_unit_macros.svh =====
// Assertion macros shared by the heap queue modules.
`ifndef BINARY_MIN_HEAP_QUEUE_UNIT_MACROS_SVH
`define BINARY_MIN_HEAP_QUEUE_UNIT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define BMHQ_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define BMHQ_ASSERT_NXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed");
`endif

// ===== rtl/bmhq_pkg.sv =====
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared types and constants of the binary min-heap queue.
// ----------------------------------------------------------------------------
package bmhq_pkg;
    localparam int unsigned CAPACITY_DEF  = 256;
    localparam int unsigned KEY_WIDTH_DEF = 32;
    localparam int unsigned OUT_KEY_W     = 32;
    localparam int unsigned COUNT_W       = 9;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_POP_EMPTY  = 2'd1,
        ST_INS_FULL   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_POP    = 2'd1,
        CMD_REJECT = 2'd2
    } cmd_kind_t;

    typedef enum logic [3:0] {
        S_IDLE, S_INS_WR, S_UP_RD, S_UP_CMP, S_POP_RD_LAST, S_POP_WR_ROOT,
        S_DN_RD_L, S_DN_RD_R, S_DN_CMP, S_DN_WR, S_ROOT_RD, S_ROOT_WAIT, S_DONE
    } bk_state_t;
endpackage

// ===== rtl/bmhq_front.sv =====
// ----------------------------------------------------------------------------
// bmhq_front
// Accepts requests, classifies them against the projected count and queues
// them for the back end.
// ----------------------------------------------------------------------------
module bmhq_front #(
    parameter int unsigned CAPACITY  = bmhq_pkg::CAPACITY_DEF,
    parameter int unsigned KEY_WIDTH = bmhq_pkg::KEY_WIDTH_DEF,
    parameter int unsigned CW        = $clog2(CAPACITY + 1)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      op,
    input  logic [31:0]               key_in,
    output logic                      q_valid,
    input  logic                      q_ready,
    output bmhq_pkg::cmd_kind_t       q_kind,
    output bmhq_pkg::status_t         q_status,
    output logic [KEY_WIDTH-1:0]      q_key
);
    import bmhq_pkg::*;

    logic [CW-1:0]        proj_reg, proj_next;
    logic [1:0]           n_reg, n_next;
    logic                 rp_reg, rp_next, wp_reg, wp_next;
    cmd_kind_t            kind_mem [2];
    status_t              stat_mem [2];
    logic [KEY_WIDTH-1:0] key_mem  [2];
    cmd_kind_t            kind_c;
    status_t              stat_c;
    logic                 acc, deq;

    assign in_ready = (n_reg != 2'd2);
    assign acc      = in_valid && in_ready;
    assign q_valid  = (n_reg != 2'd0);
    assign deq      = q_valid && q_ready;
    assign q_kind   = kind_mem[rp_reg];
    assign q_status = stat_mem[rp_reg];
    assign q_key    = key_mem[rp_reg];

    always_comb
    begin
        kind_c    = CMD_INSERT;
        stat_c    = ST_OK;
        proj_next = proj_reg;
        if (op)
        begin
            if (proj_reg == '0)
            begin
                kind_c = CMD_REJECT;
                stat_c = ST_POP_EMPTY;
            end
            else
            begin
                kind_c = CMD_POP;
                if (acc) proj_next = proj_reg - 1'b1;
            end
        end
        else if (proj_reg == CW'(CAPACITY))
        begin
            kind_c = CMD_REJECT;
            stat_c = ST_INS_FULL;
        end
        else if (acc)
        begin
            proj_next = proj_reg + 1'b1;
        end
        n_next  = n_reg + {1'b0, acc} - {1'b0, deq};
        wp_next = wp_reg ^ acc;
        rp_next = rp_reg ^ deq;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            proj_reg <= '0;
            n_reg    <= '0;
            rp_reg   <= 1'b0;
            wp_reg   <= 1'b0;
        end
        else
        begin
            proj_reg <= proj_next;
            n_reg    <= n_next;
            rp_reg   <= rp_next;
            wp_reg   <= wp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            kind_mem[wp_reg] <= kind_c;
            stat_mem[wp_reg] <= stat_c;
            key_mem[wp_reg]  <= KEY_WIDTH'($signed(key_in));
        end
    end

    `include "binary_min_heap_queue_unit_macros.svh"
    `BMHQ_ASSERT_IMP(a_q_bound, clk, rst_n, 1'b1, n_reg != 2'd3)
    `BMHQ_ASSERT_IMP(a_proj_bound, clk, rst_n, 1'b1, proj_reg <= CW'(CAPACITY))
    `BMHQ_ASSERT_NXT(a_full_stall, clk, rst_n, (n_reg == 2'd2) && !deq, !in_ready)
endmodule

// ===== rtl/bmhq_back.sv =====
// ----------------------------------------------------------------------------
// bmhq_back
// Carries out queued inserts and pops on the heap memory and registers the
// result.
// ----------------------------------------------------------------------------
module bmhq_back #(
    parameter int unsigned CAPACITY  = bmhq_pkg::CAPACITY_DEF,
    parameter int unsigned KEY_WIDTH = bmhq_pkg::KEY_WIDTH_DEF,
    parameter int unsigned CW        = $clog2(CAPACITY + 1),
    parameter int unsigned AW        = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_valid,
    output logic                      q_ready,
    input  bmhq_pkg::cmd_kind_t       q_kind,
    input  bmhq_pkg::status_t         q_status,
    input  logic [KEY_WIDTH-1:0]      q_key,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [31:0]               popped_key,
    output logic [31:0]               min_key,
    output logic [8:0]                entry_count,
    output logic                      heap_empty,
    output logic [1:0]                status
);
    import bmhq_pkg::*;

    logic [KEY_WIDTH-1:0] mem [CAPACITY];
    logic [KEY_WIDTH-1:0] rd_data;
    logic                 we, re;
    logic [AW-1:0]        wa, ra;
    logic [KEY_WIDTH-1:0] wd;

    bk_state_t            st_reg, st_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [CW:0]          idx_reg, idx_next;
    logic [KEY_WIDTH-1:0] cur_reg, cur_next, lk_reg, lk_next;
    logic [CW:0]          ci_reg, ci_next;
    logic [KEY_WIDTH-1:0] pop_reg, pop_next;
    status_t              sta_reg, sta_next;
    logic                 ov_reg, ov_next;
    logic [31:0]          pk_reg, pk_next, mk_reg, mk_next;
    logic [CW-1:0]        ec_reg, ec_next;
    logic [CW:0]          par, lch, rch;
    logic [KEY_WIDTH-1:0] cur_enc, rd_enc, lk_enc;

    always_ff @(posedge clk)
    begin
        if (we) mem[wa] <= wd;
        if (re) rd_data <= mem[ra];
    end

    function automatic logic [31:0] sext(input logic [KEY_WIDTH-1:0] k);
        logic [63:0] v;
        v = {{(64-KEY_WIDTH){k[KEY_WIDTH-1]}}, k};
        return v[31:0];
    endfunction

    assign par = (idx_reg - 1'b1) >> 1;
    assign lch = {idx_reg[CW-1:0], 1'b1};
    assign rch = lch + 1'b1;
    assign cur_enc = cur_reg ^ {1'b1, {(KEY_WIDTH-1){1'b0}}};
    assign rd_enc  = rd_data ^ {1'b1, {(KEY_WIDTH-1){1'b0}}};
    assign lk_enc  = lk_reg ^ {1'b1, {(KEY_WIDTH-1){1'b0}}};

    assign q_ready    = (st_reg == S_IDLE) && !ov_reg;
    assign out_valid  = ov_reg;
    assign popped_key = pk_reg;
    assign min_key    = mk_reg;
    assign entry_count = 9'(ec_reg);
    assign heap_empty = (ec_reg == '0);
    assign status     = sta_reg;

    always_comb
    begin
        st_next  = st_reg;
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        cur_next = cur_reg;
        lk_next  = lk_reg;
        ci_next  = ci_reg;
        pop_next = pop_reg;
        sta_next = sta_reg;
        ov_next  = ov_reg && !out_ready;
        pk_next  = pk_reg;
        mk_next  = mk_reg;
        ec_next  = ec_reg;
        we = 1'b0; re = 1'b0;
        wa = '0; ra = '0; wd = cur_reg;
        case (st_reg)
            S_IDLE:
            begin
                if (q_valid && !ov_reg)
                begin
                    sta_next = q_status;
                    pop_next = '0;
                    cur_next = q_key;
                    case (q_kind)
                        CMD_INSERT:
                        begin
                            idx_next = {1'b0, cnt_reg};
                            cnt_next = cnt_reg + 1'b1;
                            st_next  = S_INS_WR;
                        end
                        CMD_POP:
                        begin
                            re = 1'b1; ra = '0;
                            cnt_next = cnt_reg - 1'b1;
                            st_next  = S_POP_RD_LAST;
                        end
                        default: st_next = S_ROOT_RD;
                    endcase
                end
            end
            S_INS_WR:
            begin
                we = 1'b1; wa = AW'(idx_reg); wd = cur_reg;
                st_next = (idx_reg == '0) ? S_ROOT_RD : S_UP_RD;
            end
            S_UP_RD:
            begin
                re = 1'b1; ra = AW'(par);
                st_next = S_UP_CMP;
            end
            S_UP_CMP:
            begin
                if (rd_enc > cur_enc)
                begin
                    we = 1'b1; wa = AW'(idx_reg); wd = rd_data;
                    idx_next = par;
                    st_next  = S_INS_WR;
                end
                else
                begin
                    st_next = S_ROOT_RD;
                end
            end
            S_POP_RD_LAST:
            begin
                pop_next = rd_data;
                re = 1'b1; ra = AW'(cnt_reg);
                st_next = S_POP_WR_ROOT;
            end
            S_POP_WR_ROOT:
            begin
                cur_next = rd_data;
                idx_next = '0;
                if (cnt_reg == '0)
                begin
                    st_next = S_ROOT_RD;
                end
                else
                begin
                    we = 1'b1; wa = '0; wd = rd_data;
                    st_next = S_DN_RD_L;
                end
            end
            S_DN_RD_L:
            begin
                if (lch >= {1'b0, cnt_reg})
                begin
                    st_next = S_ROOT_RD;
                end
                else
                begin
                    re = 1'b1; ra = AW'(lch);
                    st_next = S_DN_RD_R;
                end
            end
            S_DN_RD_R:
            begin
                lk_next = rd_data;
                ci_next = lch;
                if (rch < {1'b0, cnt_reg})
                begin
                    re = 1'b1; ra = AW'(rch);
                    st_next = S_DN_CMP;
                end
                else
                begin
                    st_next = S_DN_WR;
                end
            end
            S_DN_CMP:
            begin
                if (!(lk_enc < rd_enc))
                begin
                    lk_next = rd_data;
                    ci_next = rch;
                end
                st_next = S_DN_WR;
            end
            S_DN_WR:
            begin
                if (lk_enc < cur_enc)
                begin
                    we = 1'b1; wa = AW'(idx_reg); wd = lk_reg;
                    idx_next = ci_reg;
                    st_next  = S_ROOT_WAIT;
                end
                else
                begin
                    st_next = S_ROOT_RD;
                end
            end
            S_ROOT_WAIT:
            begin
                we = 1'b1; wa = AW'(idx_reg); wd = cur_reg;
                st_next = S_DN_RD_L;
            end
            S_ROOT_RD:
            begin
                re = 1'b1; ra = '0;
                st_next = S_DONE;
            end
            S_DONE:
            begin
                pk_next = (sta_reg == ST_OK) ? sext(pop_reg) : '0;
                mk_next = (cnt_reg == '0) ? '0 : sext(rd_data);
                ec_next = cnt_reg;
                ov_next = 1'b1;
                st_next = S_IDLE;
            end
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= S_IDLE;
            cnt_reg <= '0;
            ov_reg  <= 1'b0;
            ec_reg  <= '0;
        end
        else
        begin
            st_reg  <= st_next;
            cnt_reg <= cnt_next;
            ov_reg  <= ov_next;
            ec_reg  <= ec_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        cur_reg <= cur_next;
        lk_reg  <= lk_next;
        ci_reg  <= ci_next;
        pop_reg <= pop_next;
        sta_reg <= sta_next;
        pk_reg  <= pk_next;
        mk_reg  <= mk_next;
    end

    `include "binary_min_heap_queue_unit_macros.svh"
    `BMHQ_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, cnt_reg <= CW'(CAPACITY))
    `BMHQ_ASSERT_NXT(a_hold_out, clk, rst_n, out_valid && !out_ready, out_valid)
    `BMHQ_ASSERT_IMP(a_no_take_busy, clk, rst_n, st_reg != S_IDLE, !q_ready)
endmodule

// ===== rtl/binary_min_heap_queue_unit.sv =====
// ----------------------------------------------------------------------------
// binary_min_heap_queue_unit
// Bounded binary min-heap priority queue with insert and pop requests.
// ----------------------------------------------------------------------------
// Each request yields one result. An insert writes the key and climbs level by
// level towards the root; a pop reads the root and the last entry, moves the
// last entry to the root and sifts it down level by level; a rejected request
// only reads the root. Each request ends by reading the root for min_key. The
// back end takes no new request until the result has been handed over. The
// heap memory has a single read port and a single write port. A two-entry
// request queue lets the next requests be taken while the back end works.
module binary_min_heap_queue_unit #(
    parameter int unsigned CAPACITY  = bmhq_pkg::CAPACITY_DEF,
    parameter int unsigned KEY_WIDTH = bmhq_pkg::KEY_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [31:0] key_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] popped_key,
    output logic [31:0] min_key,
    output logic [8:0]  entry_count,
    output logic        heap_empty,
    output logic [1:0]  status
);
    import bmhq_pkg::*;

    logic                 q_valid, q_ready;
    cmd_kind_t            q_kind;
    status_t              q_status;
    logic [KEY_WIDTH-1:0] q_key;

    bmhq_front #(.CAPACITY(CAPACITY), .KEY_WIDTH(KEY_WIDTH)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .op(op), .key_in(key_in), .q_valid(q_valid), .q_ready(q_ready),
        .q_kind(q_kind), .q_status(q_status), .q_key(q_key)
    );

    bmhq_back #(.CAPACITY(CAPACITY), .KEY_WIDTH(KEY_WIDTH)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready),
        .q_kind(q_kind), .q_status(q_status), .q_key(q_key),
        .out_valid(out_valid), .out_ready(out_ready), .popped_key(popped_key),
        .min_key(min_key), .entry_count(entry_count), .heap_empty(heap_empty),
        .status(status)
    );
endmodule

// ===== sim/binary_min_heap_queue_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Binary min-heap queue unit testbench
// Drives insert and pop requests through the request channel with random
// idling on both sides. A scoreboard keeps its own heap of signed keys,
// predicts every result and checks each returned result field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

class heap_scoreboard;
    logic signed [31:0] keys [0:255];
    int unsigned        held;
    logic [31:0]        exp_popped [$];
    logic [31:0]        exp_min [$];
    logic [8:0]         exp_count [$];
    logic               exp_empty [$];
    bmhq_pkg::status_t  exp_status [$];
    int unsigned        errors;

    function new();
        held = 0;
        errors = 0;
    endfunction

    function void swap_keys(int unsigned a, int unsigned b);
        logic signed [31:0] t;
        t = keys[a];
        keys[a] = keys[b];
        keys[b] = t;
    endfunction

    function void note_request(logic op, logic signed [31:0] key);
        logic signed [31:0] popped;
        bmhq_pkg::status_t  st;
        int unsigned        i;
        int unsigned        l;
        int unsigned        c;
        popped = 0;
        st = bmhq_pkg::ST_OK;
        if (op == 1'b0)
        begin
            if (held >= 256)
            begin
                st = bmhq_pkg::ST_INS_FULL;
            end
            else
            begin
                keys[held] = key;
                i = held;
                held++;
                while (i > 0 && keys[(i - 1) / 2] > keys[i])
                begin
                    swap_keys((i - 1) / 2, i);
                    i = (i - 1) / 2;
                end
            end
        end
        else if (held == 0)
        begin
            st = bmhq_pkg::ST_POP_EMPTY;
        end
        else
        begin
            popped = keys[0];
            held--;
            keys[0] = keys[held];
            i = 0;
            forever
            begin
                l = 2 * i + 1;
                if (l + 1 < held) c = (keys[l] < keys[l + 1]) ? l : l + 1;
                else if (l < held) c = l;
                else break;
                if (keys[c] < keys[i])
                begin
                    swap_keys(c, i);
                    i = c;
                end
                else break;
            end
        end
        exp_popped = {exp_popped, popped};
        exp_min    = {exp_min, (held > 0) ? keys[0] : 32'd0};
        exp_count  = {exp_count, held[8:0]};
        exp_empty  = {exp_empty, held == 0};
        exp_status = {exp_status, st};
    endfunction

    function void check_result(logic [31:0] popped, logic [31:0] mn, logic [8:0] cnt,
                               logic empty, logic [1:0] st);
        logic [31:0] e_popped;
        logic [31:0] e_min;
        logic [8:0]  e_count;
        logic        e_empty;
        logic [1:0]  e_status;
        if (exp_status.size() == 0)
        begin
            $error("Result received with no request outstanding");
            errors++;
            return;
        end
        e_popped = exp_popped.pop_front();
        e_min = exp_min.pop_front();
        e_count = exp_count.pop_front();
        e_empty = exp_empty.pop_front();
        e_status = exp_status.pop_front();
        if (popped !== e_popped)
        begin
            $error("popped_key expected %0d actual %0d", $signed(e_popped), $signed(popped));
            errors++;
        end
        if (mn !== e_min)
        begin
            $error("min_key expected %0d actual %0d", $signed(e_min), $signed(mn));
            errors++;
        end
        if (cnt !== e_count)
        begin
            $error("entry_count expected %0d actual %0d", e_count, cnt);
            errors++;
        end
        if (empty !== e_empty)
        begin
            $error("heap_empty expected %0d actual %0d", e_empty, empty);
            errors++;
        end
        if (st !== e_status)
        begin
            $error("status expected %0d actual %0d", e_status, st);
            errors++;
        end
    endfunction

    function int unsigned pending();
        return exp_status.size();
    endfunction
endclass

module binary_min_heap_queue_unit_tb;
    import bmhq_pkg::*;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;
    localparam int   STALL_LIMIT = 5000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        op;
    logic [31:0] key_in;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] popped_key;
    logic [31:0] min_key;
    logic [8:0]  entry_count;
    logic        heap_empty;
    logic [1:0]  status;

    heap_scoreboard heap_sb;
    bit             calm_phase;
    int             quiet_cycles;
    int             out_idle;

    binary_min_heap_queue_unit uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .op(op), .key_in(key_in),
        .out_valid(out_valid), .out_ready(out_ready),
        .popped_key(popped_key), .min_key(min_key), .entry_count(entry_count),
        .heap_empty(heap_empty), .status(status)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    task automatic send_request(logic o, logic [31:0] k);
        if (!calm_phase && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        key_in <= k;
        do @(posedge clk); while (!in_ready);
        heap_sb.note_request(o, k);
    endtask

    function automatic logic [31:0] random_key();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(0, 7) - 4;
            default: return $urandom;
        endcase
    endfunction

    // Results are sampled at the edge and the receiver idles in bursts.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                heap_sb.check_result(popped_key, min_key, entry_count, heap_empty, status);
            if (!calm_phase && out_idle > 0)
            begin
                out_ready <= 1'b0;
                out_idle <= out_idle - 1;
            end
            else if (!calm_phase && $urandom_range(0, 12) == 0)
            begin
                out_ready <= 1'b0;
                out_idle <= $urandom_range(0, 15);
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        int n;
        int target;
        heap_sb = new();
        calm_phase = 1'b0;
        quiet_cycles = 0;
        out_idle = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        op = OP_INSERT;
        key_in = '0;
        out_ready = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty pop, extremes, equal keys, then drain past empty.
        send_request(OP_POP, 32'h0);
        send_request(OP_INSERT, 32'h7fff_ffff);
        send_request(OP_INSERT, 32'h8000_0000);
        send_request(OP_INSERT, 32'h0000_0000);
        send_request(OP_INSERT, 32'hffff_ffff);
        send_request(OP_INSERT, 32'h0000_0005);
        send_request(OP_INSERT, 32'h0000_0005);
        send_request(OP_INSERT, 32'h0000_0005);
        send_request(OP_INSERT, 32'h8000_0000);
        send_request(OP_INSERT, 32'h5555_aaaa);
        send_request(OP_INSERT, 32'haaaa_5555);
        for (int i = 0; i < 11; i++)
            send_request(OP_POP, 32'hffff_ffff);

        // Fill to capacity, try two more inserts, then drain halfway.
        for (int i = 0; i < 257; i++)
            send_request(OP_INSERT, random_key());
        send_request(OP_INSERT, 32'h1234_5678);
        for (int i = 0; i < 130; i++)
            send_request(OP_POP, random_key());

        // Random walk with phases biased towards growth or shrinkage.
        n = 0;
        while (n < 1600)
        begin
            target = $urandom_range(10, 90);
            for (int j = 0; j < 100 && n < 1600; j++)
            begin
                if (n >= 1400) calm_phase = 1'b1;
                send_request($urandom_range(1, 100) > target ? OP_POP : OP_INSERT,
                             random_key());
                n++;
            end
        end
        in_valid <= 1'b0;
        while (heap_sb.pending() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (heap_sb.errors == 0 && heap_sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
